[sv/efs_pkg.sv]
// -----------------------------------------------------------------------------
// efs_pkg
// Shared types and constants for the encoder frequency stepper.
// -----------------------------------------------------------------------------
package efs_pkg;

   // fixed field widths
   localparam int CLK_W  = 30;   // timer clock in Hz
   localparam int SPC_W  = 13;   // samples per output period
   localparam int FREQ_W = 20;   // min / max frequency registers
   localparam int OUTF_W = 30;   // realized frequency
   localparam int QUO_W  = 31;   // divider quotient bits, enough for clock / 1 + rounding
   localparam int CNT_W  = 5;    // divider step counter
   localparam int CSR_W  = 30;   // configuration write data
   localparam int STEP_W = 7;    // frequency step, up to 100

   // configuration reset values
   localparam logic [CLK_W-1:0]  CLOCK_HZ_RST  = 30'd150000000;
   localparam logic [SPC_W-1:0]  SAMPLES_RST   = 13'd500;
   localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = 20'd1;
   localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = 20'd25000;

   // decade thresholds and step sizes
   localparam logic [OUTF_W-1:0] DECADE_LO  = 30'd100;
   localparam logic [OUTF_W-1:0] DECADE_HI  = 30'd1000;
   localparam logic [STEP_W-1:0] STEP_FINE  = 7'd1;
   localparam logic [STEP_W-1:0] STEP_MID   = 7'd10;
   localparam logic [STEP_W-1:0] STEP_WIDE  = 7'd100;

   typedef enum logic [1:0] {
      CSR_CLOCK_HZ,
      CSR_SAMPLES,
      CSR_MIN_FREQ,
      CSR_MAX_FREQ
   } efs_csr_type;

   // which division is in flight
   typedef enum logic [1:0] {
      PH_ACTUAL,    // frequency of the current reload
      PH_RELOAD,    // rounded reload of the desired frequency
      PH_VERIFY     // frequency of the new reload
   } efs_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIVS,
      ST_DIVW,
      ST_STEP,
      ST_FIX,
      ST_EMIT
   } efs_state_type;

   typedef struct packed {
      logic          accept;
      logic          mul_en;
      logic          div_start;
      logic          step_en;
      logic          fix_en;
      logic          emit;
      efs_phase_type phase;
   } efs_cmd_type;

   typedef struct packed {
      logic diff_zero;
      logic div_done;
      logic out_free;
   } efs_sts_type;

endpackage

[sv/efs_div.sv]
// -----------------------------------------------------------------------------
// efs_div
// Restoring divider, one quotient bit per cycle. The numerator must be below
// den * 2^QUO_W, which the callers guarantee.
// -----------------------------------------------------------------------------
module efs_div #(
   parameter int DEN_W = 46
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DEN_W-1:0]         num,
   input  logic [DEN_W-1:0]         den,
   output logic                     done,
   output logic [efs_pkg::QUO_W-1:0] quot
);

   logic [DEN_W-1:0]          rem_ff, rem_in;
   logic [efs_pkg::QUO_W-1:0] low_ff, low_in;   // numerator bits out, quotient bits in
   logic [efs_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   logic [DEN_W:0]            trial;
   logic [DEN_W:0]            sub;
   logic                      ge;

   always_comb begin
      trial   = {rem_ff, low_ff[efs_pkg::QUO_W-1]};
      sub     = trial - {1'b0, den};
      ge      = ~sub[DEN_W];
      rem_in  = rem_ff;
      low_in  = low_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = DEN_W'(num >> efs_pkg::QUO_W);
         low_in = num[efs_pkg::QUO_W-1:0];
         cnt_in = efs_pkg::CNT_W'(efs_pkg::QUO_W);
      end else if (cnt_ff != '0) begin
         rem_in  = ge ? sub[DEN_W-1:0] : trial[DEN_W-1:0];
         low_in  = {low_ff[efs_pkg::QUO_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == efs_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
   end

   assign done = done_ff;
   assign quot = low_ff;

endmodule

[sv/efs_dp.sv]
// -----------------------------------------------------------------------------
// efs_dp
// Datapath: configuration registers, count tracking, shared multiplier and
// divider, step and reload arithmetic, output register.
// -----------------------------------------------------------------------------
module efs_dp #(
   parameter int COUNT_WIDTH  = 16,
   parameter int RELOAD_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  efs_pkg::efs_cmd_type        cmd,
   output efs_pkg::efs_sts_type        sts,
   input  logic [COUNT_WIDTH-1:0]      encoder_count,
   input  logic                        csr_valid,
   input  logic [1:0]                  csr_index,
   input  logic [efs_pkg::CSR_W-1:0]   csr_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [RELOAD_WIDTH-1:0]     reload_value,
   output logic [efs_pkg::OUTF_W-1:0]  realized_freq_hz,
   output logic                        changed
);

   localparam int OPND_W = (RELOAD_WIDTH + 1 > efs_pkg::OUTF_W) ? RELOAD_WIDTH + 1
                                                               : efs_pkg::OUTF_W;
   localparam int DEN_W  = efs_pkg::SPC_W + OPND_W;
   localparam logic [RELOAD_WIDTH-1:0] RELOAD_RST = RELOAD_WIDTH'(15);

   // configuration
   logic [efs_pkg::CLK_W-1:0]  clock_hz_ff;
   logic [efs_pkg::SPC_W-1:0]  samples_ff;
   logic [efs_pkg::FREQ_W-1:0] min_freq_ff;
   logic [efs_pkg::FREQ_W-1:0] max_freq_ff;

   // item state
   logic [COUNT_WIDTH-1:0]     last_count_ff;
   logic [RELOAD_WIDTH-1:0]    cur_reload_ff;
   logic                       up_ff;
   logic [DEN_W-1:0]           den_ff, den_in;
   logic [efs_pkg::OUTF_W-1:0] desired_ff, desired_in;
   logic [RELOAD_WIDTH-1:0]    new_reload_ff, new_reload_in;

   // output word
   logic                       rsp_valid_ff;
   logic [RELOAD_WIDTH-1:0]    rsp_reload_ff;
   logic [efs_pkg::OUTF_W-1:0] rsp_freq_ff;
   logic                       rsp_changed_ff;

   logic [COUNT_WIDTH-1:0]     diff;
   logic [efs_pkg::SPC_W-1:0]  s_eff;
   logic [OPND_W-1:0]          opnd;
   logic [DEN_W-1:0]           num;
   logic                       div_done;
   logic [efs_pkg::QUO_W-1:0]  quot;
   logic [efs_pkg::OUTF_W-1:0] actual;
   logic [efs_pkg::STEP_W-1:0] step;
   logic [efs_pkg::OUTF_W:0]   sum_up;
   logic [efs_pkg::OUTF_W:0]   floor_dn;
   logic [efs_pkg::OUTF_W-1:0] min_ext;
   logic [efs_pkg::OUTF_W-1:0] cand;
   logic [efs_pkg::QUO_W-1:0]  qm1;
   logic [RELOAD_WIDTH-1:0]    rl;

   assign diff  = encoder_count - last_count_ff;
   assign s_eff = (samples_ff == '0) ? efs_pkg::SPC_W'(1) : samples_ff;

   // multiplier operand per phase
   always_comb begin
      unique case (cmd.phase)
         efs_pkg::PH_ACTUAL: opnd = OPND_W'(cur_reload_ff) + OPND_W'(1);
         efs_pkg::PH_RELOAD: opnd = OPND_W'(desired_ff);
         efs_pkg::PH_VERIFY: opnd = OPND_W'(new_reload_ff) + OPND_W'(1);
         default:            opnd = '0;
      endcase
   end

   assign den_in = DEN_W'(s_eff) * DEN_W'(opnd);

   // rounding adds half the divisor for the reload computation
   assign num = (cmd.phase == efs_pkg::PH_RELOAD) ? DEN_W'(clock_hz_ff) + (den_ff >> 1)
                                                   : DEN_W'(clock_hz_ff);

   efs_div #(
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (num),
      .den   (den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   // quotient of a plain frequency division never exceeds clock_hz
   assign actual  = quot[efs_pkg::OUTF_W-1:0];
   assign min_ext = efs_pkg::OUTF_W'(min_freq_ff);

   // next frequency: decade step, clamps
   always_comb begin
      priority if (actual < efs_pkg::DECADE_LO) step = efs_pkg::STEP_FINE;
      else if (actual < efs_pkg::DECADE_HI)     step = efs_pkg::STEP_MID;
      else                                       step = efs_pkg::STEP_WIDE;
      sum_up   = {1'b0, actual} + (efs_pkg::OUTF_W+1)'(step);
      floor_dn = (efs_pkg::OUTF_W+1)'(min_freq_ff) + (efs_pkg::OUTF_W+1)'(step);
      if (up_ff) begin
         if (sum_up >= (efs_pkg::OUTF_W+1)'(max_freq_ff))
            cand = efs_pkg::OUTF_W'(max_freq_ff);
         else
            cand = sum_up[efs_pkg::OUTF_W-1:0];
      end else begin
         if ({1'b0, actual} <= floor_dn)
            cand = min_ext;
         else
            cand = actual - efs_pkg::OUTF_W'(step);
      end
      if (cand < min_ext)
         cand = min_ext;
      desired_in = (cand == '0) ? efs_pkg::OUTF_W'(1) : cand;
   end

   // reload from rounded quotient, saturated, then forced one tick if unchanged
   always_comb begin
      qm1 = quot - 1'b1;
      if (quot == '0)
         rl = '0;
      else if ((qm1 >> RELOAD_WIDTH) != '0)
         rl = '1;
      else
         rl = RELOAD_WIDTH'(qm1);
      new_reload_in = rl;
      if (rl == cur_reload_ff) begin
         if (up_ff) begin
            if (rl != '0)
               new_reload_in = rl - 1'b1;
         end else begin
            if (rl != '1)
               new_reload_in = rl + 1'b1;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= efs_pkg::CLOCK_HZ_RST;
         samples_ff  <= efs_pkg::SAMPLES_RST;
         min_freq_ff <= efs_pkg::MIN_FREQ_RST;
         max_freq_ff <= efs_pkg::MAX_FREQ_RST;
      end else if (csr_valid) begin
         unique case (efs_pkg::efs_csr_type'(csr_index))
            efs_pkg::CSR_CLOCK_HZ: clock_hz_ff <= csr_data[efs_pkg::CLK_W-1:0];
            efs_pkg::CSR_SAMPLES:  samples_ff  <= csr_data[efs_pkg::SPC_W-1:0];
            efs_pkg::CSR_MIN_FREQ: min_freq_ff <= csr_data[efs_pkg::FREQ_W-1:0];
            efs_pkg::CSR_MAX_FREQ: max_freq_ff <= csr_data[efs_pkg::FREQ_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_count_ff <= '0;
         cur_reload_ff <= RELOAD_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.accept && diff != '0)
            last_count_ff <= encoder_count;
         if (cmd.emit) begin
            cur_reload_ff <= new_reload_ff;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept)
         up_ff <= ~diff[COUNT_WIDTH-1];
      if (cmd.mul_en)
         den_ff <= den_in;
      if (cmd.step_en)
         desired_ff <= desired_in;
      if (cmd.fix_en)
         new_reload_ff <= new_reload_in;
      if (cmd.emit) begin
         rsp_reload_ff  <= new_reload_ff;
         rsp_freq_ff    <= actual;
         rsp_changed_ff <= (new_reload_ff != cur_reload_ff);
      end
   end

   assign sts.diff_zero = (diff == '0);
   assign sts.div_done  = div_done;
   assign sts.out_free  = ~rsp_valid_ff | rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign reload_value     = rsp_reload_ff;
   assign realized_freq_hz = rsp_freq_ff;
   assign changed          = rsp_changed_ff;

endmodule

[sv/efs_ctrl.sv]
// -----------------------------------------------------------------------------
// efs_ctrl
// Sequencer: three multiply/divide rounds per moving count, with the step
// and reload fix-up between them.
// -----------------------------------------------------------------------------
module efs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  efs_pkg::efs_sts_type sts,
   output efs_pkg::efs_cmd_type cmd
);

   efs_pkg::efs_state_type state_ff, state_in;
   efs_pkg::efs_phase_type phase_ff, phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= efs_pkg::ST_IDLE;
         phase_ff <= efs_pkg::PH_ACTUAL;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.phase     = phase_ff;
      unique case (state_ff)
         efs_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid && !sts.diff_zero) begin
               phase_in = efs_pkg::PH_ACTUAL;
               state_in = efs_pkg::ST_MUL;
            end
         end
         efs_pkg::ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in   = efs_pkg::ST_DIVS;
         end
         efs_pkg::ST_DIVS: begin
            cmd.div_start = 1'b1;
            state_in      = efs_pkg::ST_DIVW;
         end
         efs_pkg::ST_DIVW: begin
            if (sts.div_done) begin
               unique case (phase_ff)
                  efs_pkg::PH_ACTUAL: state_in = efs_pkg::ST_STEP;
                  efs_pkg::PH_RELOAD: state_in = efs_pkg::ST_FIX;
                  efs_pkg::PH_VERIFY: state_in = efs_pkg::ST_EMIT;
                  default:            state_in = efs_pkg::ST_IDLE;
               endcase
            end
         end
         efs_pkg::ST_STEP: begin
            cmd.step_en = 1'b1;
            phase_in    = efs_pkg::PH_RELOAD;
            state_in    = efs_pkg::ST_MUL;
         end
         efs_pkg::ST_FIX: begin
            cmd.fix_en = 1'b1;
            phase_in   = efs_pkg::PH_VERIFY;
            state_in   = efs_pkg::ST_MUL;
         end
         efs_pkg::ST_EMIT: begin
            // wait for the output register to free up
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = efs_pkg::ST_IDLE;
            end
         end
         default: state_in = efs_pkg::ST_IDLE;
      endcase
   end

endmodule

[sv/encoder_frequency_stepper_top.sv]
// A moving count gives its result word after three passes through the one shared
//   restoring divider.
// A new count is taken only once the word of the previous moving count is emitted; a
//   count equal to the last one is taken while idle and gives no word.
// Reset (synchronous, active high): registers to defaults, last count 0, reload 15.
// -----------------------------------------------------------------------------
// encoder_frequency_stepper_top
// Steps a waveform output frequency up or down on encoder movement and
// returns the new sample-timer reload and the frequency it realizes.
// -----------------------------------------------------------------------------
module encoder_frequency_stepper_top #(
   parameter int COUNT_WIDTH  = 16,
   parameter int RELOAD_WIDTH = 32
) (
   input  logic                                              clock,
   input  logic                                              reset,
   // encoder_count
   input  logic [((COUNT_WIDTH+7)/8)*8-1:0]                  req_tdata,
   input  logic                                              req_tvalid,
   output logic                                              req_tready,
   // reload_value, realized_freq_hz
   output logic [((RELOAD_WIDTH+efs_pkg::OUTF_W+7)/8)*8-1:0] rsp_tdata,
   // changed
   output logic                                              rsp_tuser,
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   input  logic                                              csr_valid,
   output logic                                              csr_ready,
   input  logic [1:0]                                        csr_index,
   input  logic [efs_pkg::CSR_W-1:0]                         csr_data
);

   localparam int RSP_W = ((RELOAD_WIDTH + efs_pkg::OUTF_W + 7) / 8) * 8;

   efs_pkg::efs_cmd_type       cmd;
   efs_pkg::efs_sts_type       sts;
   logic [RELOAD_WIDTH-1:0]    reload_value;
   logic [efs_pkg::OUTF_W-1:0] realized_freq_hz;

   efs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   efs_dp #(
      .COUNT_WIDTH  (COUNT_WIDTH),
      .RELOAD_WIDTH (RELOAD_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .encoder_count    (req_tdata[COUNT_WIDTH-1:0]),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_tvalid),
      .rsp_ready        (rsp_tready),
      .reload_value     (reload_value),
      .realized_freq_hz (realized_freq_hz),
      .changed          (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({realized_freq_hz, reload_value});
   assign csr_ready = 1'b1;

endmodule
